### hdl/srq_pkg.sv
// ----------------------------------------------------------------------------
// srq_pkg: shared types and constants for the selective-repeat ARQ engine
// Field widths, commands, frame types, result kinds and the transmit-window entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package srq_pkg;

  localparam int SEQ_W  = 8;
  localparam int AGE_W  = 20;
  localparam int DATA_W = 32;

  localparam logic [AGE_W-1:0] AGE_MAX     = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RST = 20'd1000;

  // input commands
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_SEND  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // received frame types
  localparam logic [1:0] FT_DATA = 2'd0;
  localparam logic [1:0] FT_ACK  = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_SEND    = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_DELIVER = 2'd2;
  localparam logic [1:0] KIND_REFUSE  = 2'd3;

  // one transmit-window entry as held in RAM
  typedef struct packed {
    logic              done;
    logic [SEQ_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
    logic [DATA_W-1:0] pl;
  } tx_ent_t;

  // one result beat
  typedef struct packed {
    logic [1:0]        kind;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data;
    logic              resend;
  } res_t;

endpackage

`default_nettype wire

### hdl/srq_ram.sv
// ----------------------------------------------------------------------------
// srq_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/selective_repeat_arq_engine_unit.sv
// ----------------------------------------------------------------------------
// selective_repeat_arq_engine_unit: selective-repeat ARQ link engine
// Transmit and receive windows kept in RAM, walked by a sequencer.
// ----------------------------------------------------------------------------
// One input beat at a time. A tick or an ack reads, then writes back, each
// outstanding transmit entry through the single RAM port pair; an ack then
// retires finished entries from the head. A data frame marks the receive
// window slot by slot, then reads out each in-order frame for delivery.
// Results leave through a one-deep output register; one result is held back
// so that tlast can mark the final one of each input beat.
`default_nettype none

module selective_repeat_arq_engine_unit #(
  parameter int WINDOW      = 8,
  parameter int SEQ_MODULUS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config: retry_timeout
  input  wire logic        cfg_wr_en,
  input  wire logic [19:0] cfg_wr_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [1:0]  in_tuser,   // command
  input  wire logic [47:0] in_tdata,   // frame_type, frame_seq, crc_good, payload
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [1:0]       out_tuser,  // kind
  output logic [47:0]      out_tdata,  // seq, data, resend
  output logic             out_tlast   // last
);
  import srq_pkg::*;

  localparam int IW   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW   = $clog2(WINDOW + 1);
  localparam int SUMW = CW + 1;
  localparam logic [IW-1:0]    SLOT_LAST = IW'(WINDOW - 1);
  localparam logic [CW-1:0]    CNT_FULL  = CW'(WINDOW);
  localparam logic [SEQ_W-1:0] SEQ_LAST  = SEQ_W'(SEQ_MODULUS - 1);
  localparam logic [SEQ_W-1:0] SEQ_ONE   = SEQ_W'(1 % SEQ_MODULUS);

  typedef enum logic [3:0] {
    S_IDLE, S_DISP, S_RX_MARK, S_RX_DRD, S_RX_DOUT, S_ACK_RD, S_ACK_WR,
    S_PR_RD, S_PR_CHK, S_TK_RD, S_TK_WR, S_FIN
  } state_t;

  state_t              state_r;
  logic [AGE_W-1:0]    timeout_r;
  logic [1:0]          cmd_r;
  logic [1:0]          ftype_r;
  logic [SEQ_W-1:0]    fseq_r;
  logic                crc_r;
  logic [DATA_W-1:0]   pl_r;
  logic [IW-1:0]       tx_head_r;
  logic [CW-1:0]       tx_count_r;
  logic [SEQ_W-1:0]    next_seq_r;
  logic [IW-1:0]       rx_head_r;
  logic [SEQ_W-1:0]    rx_base_r;
  logic [WINDOW-1:0]   rx_got_r;
  logic [CW-1:0]       idx_r;
  logic [IW-1:0]       slot_r;
  logic [SEQ_W-1:0]    scan_seq_r;
  logic                pend_v_r;
  res_t                pend_r;
  logic                out_v_r;
  res_t                out_r;
  logic                out_last_r;

  // RAM ports
  logic                tx_we, tx_re, rx_we, rx_re;
  logic [IW-1:0]       tx_waddr, tx_raddr, rx_raddr;
  tx_ent_t             tx_wdata, tx_rdata;
  logic [DATA_W-1:0]   rx_rdata;

  // result production
  logic                prod_req, prod_ok, can_emit;
  res_t                prod;

  // helpers
  logic [IW-1:0]       slot_inc, tx_head_inc, rx_head_inc;
  logic [SEQ_W-1:0]    scan_seq_inc, next_seq_inc, rx_base_inc;
  logic [SUMW-1:0]     tail_sum;
  logic [IW-1:0]       tail_slot;
  logic                idx_end;
  logic [AGE_W-1:0]    age_inc;
  logic                rx_hit, ack_hit, tk_fire;

  assign slot_inc     = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
  assign tx_head_inc  = (tx_head_r == SLOT_LAST) ? '0 : tx_head_r + 1'b1;
  assign rx_head_inc  = (rx_head_r == SLOT_LAST) ? '0 : rx_head_r + 1'b1;
  assign scan_seq_inc = (scan_seq_r == SEQ_LAST) ? '0 : scan_seq_r + 1'b1;
  assign next_seq_inc = (next_seq_r == SEQ_LAST) ? '0 : next_seq_r + 1'b1;
  assign rx_base_inc  = (rx_base_r == SEQ_LAST) ? '0 : rx_base_r + 1'b1;
  assign tail_sum     = SUMW'(tx_head_r) + SUMW'(tx_count_r);
  assign tail_slot    = (tail_sum >= SUMW'(WINDOW)) ? IW'(tail_sum - SUMW'(WINDOW))
                                                    : IW'(tail_sum);
  assign idx_end      = (idx_r + 1'b1 == tx_count_r);
  assign age_inc      = (tx_rdata.age == AGE_MAX) ? tx_rdata.age : tx_rdata.age + 1'b1;
  assign rx_hit       = (scan_seq_r == fseq_r) && !rx_got_r[slot_r];
  assign ack_hit      = (tx_rdata.tag == fseq_r) && !tx_rdata.done;
  assign tk_fire      = !tx_rdata.done && (age_inc > timeout_r);

  assign can_emit  = !out_v_r || out_tready;
  assign prod_ok   = !pend_v_r || can_emit;
  assign in_tready = (state_r == S_IDLE);

  // RAM access and result requests per state
  always_comb begin
    tx_we    = 1'b0;
    tx_waddr = slot_r;
    tx_wdata = tx_rdata;
    tx_re    = 1'b0;
    tx_raddr = slot_r;
    rx_we    = 1'b0;
    rx_re    = 1'b0;
    rx_raddr = rx_head_r;
    prod_req = 1'b0;
    prod     = '0;
    case (state_r)
      S_DISP: begin
        if (cmd_r == CMD_FRAME && crc_r && ftype_r == FT_DATA) begin
          prod_req  = 1'b1;
          prod.kind = KIND_ACK;
          prod.seq  = fseq_r;
        end else if (cmd_r == CMD_SEND) begin
          prod_req = 1'b1;
          if (tx_count_r >= CNT_FULL) begin
            prod.kind = KIND_REFUSE;
          end else begin
            prod.kind     = KIND_SEND;
            prod.seq      = next_seq_r;
            prod.data     = pl_r;
            tx_we         = 1'b1;
            tx_waddr      = tail_slot;
            tx_wdata.done = 1'b0;
            tx_wdata.tag  = next_seq_r;
            tx_wdata.age  = '0;
            tx_wdata.pl   = pl_r;
          end
        end
      end
      S_RX_MARK: rx_we = rx_hit;
      S_RX_DRD:  rx_re = rx_got_r[rx_head_r];
      S_RX_DOUT: begin
        prod_req  = 1'b1;
        prod.kind = KIND_DELIVER;
        prod.seq  = rx_base_r;
        prod.data = rx_rdata;
      end
      S_ACK_RD, S_TK_RD: tx_re = 1'b1;
      S_ACK_WR: begin
        tx_we         = ack_hit;
        tx_wdata.done = 1'b1;
      end
      S_PR_RD: begin
        tx_re    = (tx_count_r != '0);
        tx_raddr = tx_head_r;
      end
      S_TK_WR: begin
        tx_we        = !tx_rdata.done && (!tk_fire || prod_ok);
        tx_wdata.age = tk_fire ? '0 : age_inc;
        if (tk_fire) begin
          prod_req    = 1'b1;
          prod.kind   = KIND_SEND;
          prod.seq    = tx_rdata.tag;
          prod.data   = tx_rdata.pl;
          prod.resend = 1'b1;
        end
      end
      default: ;
    endcase
  end

  srq_ram #(.WIDTH($bits(tx_ent_t)), .DEPTH(WINDOW), .AW(IW)) u_tx_ram (
    .clk(clk), .wr_en(tx_we), .wr_addr(tx_waddr), .wr_data(tx_wdata),
    .rd_en(tx_re), .rd_addr(tx_raddr), .rd_data(tx_rdata)
  );

  srq_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW), .AW(IW)) u_rx_ram (
    .clk(clk), .wr_en(rx_we), .wr_addr(slot_r), .wr_data(pl_r),
    .rd_en(rx_re), .rd_addr(rx_raddr), .rd_data(rx_rdata)
  );

  // sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      timeout_r  <= TIMEOUT_RST;
      tx_head_r  <= '0;
      tx_count_r <= '0;
      next_seq_r <= SEQ_ONE;
      rx_head_r  <= '0;
      rx_base_r  <= SEQ_ONE;
      rx_got_r   <= '0;
      pend_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end

      // output register: held-back result moves out when a new one arrives
      if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      if (prod_req && prod_ok) begin
        pend_v_r <= 1'b1;
        pend_r   <= prod;
        if (pend_v_r) begin
          out_v_r    <= 1'b1;
          out_r      <= pend_r;
          out_last_r <= 1'b0;
        end
      end

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            ftype_r <= in_tdata[1:0];
            fseq_r  <= in_tdata[9:2];
            crc_r   <= in_tdata[10];
            pl_r    <= in_tdata[42:11];
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          idx_r      <= '0;
          slot_r     <= tx_head_r;
          scan_seq_r <= rx_base_r;
          state_r    <= S_FIN;
          case (cmd_r)
            CMD_FRAME: begin
              if (crc_r && ftype_r == FT_DATA) begin
                slot_r  <= rx_head_r;
                state_r <= S_RX_MARK;
              end else if (crc_r && ftype_r == FT_ACK) begin
                state_r <= (tx_count_r != '0) ? S_ACK_RD : S_FIN;
              end
            end
            CMD_SEND: begin
              if (tx_count_r < CNT_FULL) begin
                tx_count_r <= tx_count_r + 1'b1;
                next_seq_r <= next_seq_inc;
              end
            end
            CMD_TICK: state_r <= (tx_count_r != '0) ? S_TK_RD : S_FIN;
            default: ;
          endcase
        end
        S_RX_MARK: begin
          if (rx_hit) begin
            rx_got_r[slot_r] <= 1'b1;
          end
          idx_r      <= idx_r + 1'b1;
          slot_r     <= slot_inc;
          scan_seq_r <= scan_seq_inc;
          if (idx_r == CW'(WINDOW - 1)) begin
            state_r <= S_RX_DRD;
          end
        end
        S_RX_DRD: state_r <= rx_got_r[rx_head_r] ? S_RX_DOUT : S_FIN;
        S_RX_DOUT: begin
          if (prod_ok) begin
            rx_got_r[rx_head_r] <= 1'b0;
            rx_head_r <= rx_head_inc;
            rx_base_r <= rx_base_inc;
            state_r   <= S_RX_DRD;
          end
        end
        S_ACK_RD: state_r <= S_ACK_WR;
        S_ACK_WR: begin
          idx_r   <= idx_r + 1'b1;
          slot_r  <= slot_inc;
          state_r <= idx_end ? S_PR_RD : S_ACK_RD;
        end
        S_PR_RD: state_r <= (tx_count_r != '0) ? S_PR_CHK : S_FIN;
        S_PR_CHK: begin
          if (tx_rdata.done) begin
            tx_head_r  <= tx_head_inc;
            tx_count_r <= tx_count_r - 1'b1;
            state_r    <= S_PR_RD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_TK_RD: state_r <= S_TK_WR;
        S_TK_WR: begin
          if (!tk_fire || prod_ok) begin
            idx_r   <= idx_r + 1'b1;
            slot_r  <= slot_inc;
            state_r <= idx_end ? S_FIN : S_TK_RD;
          end
        end
        S_FIN: begin
          if (!pend_v_r) begin
            state_r <= S_IDLE;
          end else if (can_emit) begin
            out_v_r    <= 1'b1;
            out_r      <= pend_r;
            out_last_r <= 1'b1;
            pend_v_r   <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {7'b0, out_r.resend, out_r.data, out_r.seq};
  assign out_tlast  = out_last_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_count_r <= CNT_FULL) else $error("transmit count beyond window");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_DISP) else $error("beat not dispatched");
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    rx_base_r <= SEQ_LAST && next_seq_r <= SEQ_LAST) else $error("sequence out of range");
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r) else $error("held result left behind");

endmodule

`default_nettype wire
